// ===== rtl/seven_segment_char_serial_driver_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment character serial driver.
// All properties are sampled on the rising edge of i_clk.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_CHAR_SERIAL_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_CHAR_SERIAL_DRIVER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SSCSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SSCSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SSCSD_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sscsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscsd_pkg
// Shared types, register indexes and the character font of the driver.
// ----------------------------------------------------------------------------
package sscsd_pkg;

    localparam int unsigned PATTERN_W = 8;
    localparam int unsigned BIT_CNT_W = 3;

    // Configuration register indexes.
    localparam logic CFG_INVERT    = 1'b0;
    localparam logic CFG_LSB_FIRST = 1'b1;

    typedef struct packed {
        logic                 known;
        logic [PATTERN_W-1:0] pattern;
    } t_item;

    // Font lookup: bit 7 is segment a down to bit 0, the decimal point.
    // Unknown codes give known = 0 and an all-zero pattern.
    function automatic t_item font_lookup(input logic [7:0] c);
        t_item g;
        g.known = 1'b1;
        case (c) inside
            8'h30:        g.pattern = 8'hFC; // 0
            8'h31:        g.pattern = 8'h60; // 1
            8'h32:        g.pattern = 8'hDA; // 2
            8'h33:        g.pattern = 8'hF2; // 3
            8'h34:        g.pattern = 8'h66; // 4
            8'h35:        g.pattern = 8'hB6; // 5
            8'h36:        g.pattern = 8'hBE; // 6
            8'h37:        g.pattern = 8'hE0; // 7
            8'h38:        g.pattern = 8'hFE; // 8
            8'h39:        g.pattern = 8'hF6; // 9
            8'h41, 8'h61: g.pattern = 8'hEE; // A a
            8'h42, 8'h62: g.pattern = 8'h3E; // B b
            8'h43, 8'h63: g.pattern = 8'h1A; // C c
            8'h44, 8'h64: g.pattern = 8'h7A; // D d
            8'h45, 8'h65: g.pattern = 8'h9E; // E e
            8'h46, 8'h66: g.pattern = 8'h8E; // F f
            8'h47, 8'h67: g.pattern = 8'hBC; // G g
            8'h48:        g.pattern = 8'h6E; // H
            8'h68:        g.pattern = 8'h2E; // h
            8'h49:        g.pattern = 8'h60; // I
            8'h69:        g.pattern = 8'h20; // i
            8'h4A, 8'h6A: g.pattern = 8'hF8; // J j
            8'h4C:        g.pattern = 8'h1C; // L
            8'h4E, 8'h6E: g.pattern = 8'h2A; // N n
            8'h4F:        g.pattern = 8'hFC; // O
            8'h6F:        g.pattern = 8'h3A; // o
            8'h50:        g.pattern = 8'hCE; // P
            8'h51, 8'h71: g.pattern = 8'hE6; // Q q
            8'h52, 8'h72: g.pattern = 8'h0A; // R r
            8'h53, 8'h73: g.pattern = 8'hB6; // S s
            8'h54, 8'h74: g.pattern = 8'h1E; // T t
            8'h55:        g.pattern = 8'h7C; // U
            8'h75:        g.pattern = 8'h38; // u
            8'h59, 8'h79: g.pattern = 8'h76; // Y y
            8'h5F:        g.pattern = 8'h10; // underscore
            8'h2D:        g.pattern = 8'h02; // minus
            8'h3D:        g.pattern = 8'h12; // equals
            8'h5B:        g.pattern = 8'h9C; // left bracket
            8'h5D:        g.pattern = 8'hF0; // right bracket
            8'h22:        g.pattern = 8'h44; // double quote
            8'h27:        g.pattern = 8'h10; // apostrophe
            8'h2E, 8'h2C: g.pattern = 8'h01; // full stop and comma
            8'h20:        g.pattern = 8'h00; // space
            default: begin
                g.known   = 1'b0;
                g.pattern = '0;
            end
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/sscsd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscsd_in_if
// Character input channel: one character code per beat.
// ----------------------------------------------------------------------------
interface sscsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

// ===== rtl/sscsd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscsd_out_if
// Serial output channel: one data line bit per beat with its pattern.
// ----------------------------------------------------------------------------
interface sscsd_out_if;
    logic       valid;
    logic       ready;
    logic       serial_bit;
    logic [7:0] segment_pattern;
    logic       symbol_known;
    logic       last_bit;

    modport source (output valid, output serial_bit, output segment_pattern,
                    output symbol_known, output last_bit, input ready);
    modport sink   (input valid, input serial_bit, input segment_pattern,
                    input symbol_known, input last_bit, output ready);
endinterface

// ===== rtl/sscsd_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscsd_decode
// Input register stage: looks the character up in the font and applies the
// optional common-anode inversion.
// ----------------------------------------------------------------------------
module sscsd_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sscsd_in_if.sink         i_in,
    input  logic             i_invert,
    input  logic             i_take,
    output logic             o_valid,
    output sscsd_pkg::t_item o_item
);

    logic             r_valid;
    sscsd_pkg::t_item r_item;
    sscsd_pkg::t_item n_item;
    sscsd_pkg::t_item w_glyph;

    assign i_in.ready = !r_valid || i_take;

    // A rejected character keeps an all-zero pattern; inversion applies only
    // to characters in the font.
    always_comb begin
        w_glyph        = sscsd_pkg::font_lookup(i_in.char_code);
        n_item.known   = w_glyph.known;
        n_item.pattern = w_glyph.known
                       ? (w_glyph.pattern ^ {sscsd_pkg::PATTERN_W{i_invert}})
                       : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/sscsd_serial.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscsd_serial
// Output register stage: shifts the pattern out one bit per beat and marks
// the final beat of each character.
// ----------------------------------------------------------------------------
module sscsd_serial (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sscsd_pkg::t_item i_item,
    input  logic             i_lsb_first,
    output logic             o_take,
    sscsd_out_if.source      o_out
);

    logic                            r_valid;
    sscsd_pkg::t_item                r_item;
    logic [sscsd_pkg::BIT_CNT_W-1:0] r_cnt;
    logic [sscsd_pkg::BIT_CNT_W-1:0] w_pos;
    logic                            w_last;
    logic                            w_beat;

    // A rejected character is a single beat on its own.
    assign w_last = !r_item.known || (r_cnt == {sscsd_pkg::BIT_CNT_W{1'b1}});
    assign w_beat = r_valid && o_out.ready;
    assign o_take = !r_valid || (o_out.ready && w_last);
    assign w_pos  = i_lsb_first ? r_cnt : ~r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_item;
            r_cnt  <= '0;
        end else if (w_beat) begin
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.serial_bit      = r_item.pattern[w_pos];
    assign o_out.segment_pattern = r_item.pattern;
    assign o_out.symbol_known    = r_item.known;
    assign o_out.last_bit        = w_last;

endmodule

// ===== rtl/seven_segment_char_serial_driver.sv =====
`timescale 1ns / 1ps
// A character passes through the input register stage and then the output register
// stage before its first beat is offered, and a stall at the output holds it back.
// A known character goes out as eight beats and a rejected one as a single beat;
// the output register stage sends one bit per beat and waits while the receiver stalls.
// A new character is taken while the previous one is still shifting out.
// Reset is synchronous and active low; it empties both stages and clears both
// configuration registers.
// ----------------------------------------------------------------------------
// seven_segment_char_serial_driver
// Seven-segment character decoder with a serial shift-out of the pattern.
// ----------------------------------------------------------------------------
module seven_segment_char_serial_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data,
    sscsd_in_if.sink    i_in,
    sscsd_out_if.source o_out
);

    logic             r_invert;
    logic             r_lsb_first;
    logic             w_valid;
    logic             w_take;
    sscsd_pkg::t_item w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert    <= 1'b0;
            r_lsb_first <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sscsd_pkg::CFG_INVERT:    r_invert    <= i_cfg_data;
                sscsd_pkg::CFG_LSB_FIRST: r_lsb_first <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sscsd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_invert(r_invert),
        .i_take  (w_take),
        .o_valid (w_valid),
        .o_item  (w_item)
    );

    sscsd_serial u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid),
        .i_item     (w_item),
        .i_lsb_first(r_lsb_first),
        .o_take     (w_take),
        .o_out      (o_out)
    );

endmodule

// ===== rtl/sscsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscsd_checker
// Port-level checks on the serial output of the driver, bound to the top.
// ----------------------------------------------------------------------------
`include "seven_segment_char_serial_driver_defines.svh"

module sscsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_serial_bit,
    input logic [7:0] i_segment_pattern,
    input logic       i_symbol_known,
    input logic       i_last_bit
);

    // A rejected character is one all-zero beat that closes at once.
    `SSCSD_ASSERT_SAME(a_reject_beat, i_out_valid && !i_symbol_known, i_last_bit && (i_segment_pattern == 8'h00) && !i_serial_bit, "rejected character beat is malformed")

    // Once a known beat that is not the last goes out, the rest of the character follows.
    `SSCSD_ASSERT_NEXT(a_char_continues, i_out_valid && i_out_ready && i_symbol_known && !i_last_bit, i_out_valid && i_symbol_known && $stable(i_segment_pattern), "character broken off before its last beat")

    // Nothing is offered in the cycle after reset.
    `SSCSD_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !i_out_valid, "output valid straight after reset")

    // A stalled beat holds its contents.
    `SSCSD_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_serial_bit) && $stable(i_last_bit), "stalled beat changed")

endmodule

bind seven_segment_char_serial_driver sscsd_checker u_sscsd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_serial_bit     (o_out.serial_bit),
    .i_segment_pattern(o_out.segment_pattern),
    .i_symbol_known   (o_out.symbol_known),
    .i_last_bit       (o_out.last_bit)
);

// ===== verif/sscsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sscsd_scoreboard
// Watches the configuration port and both channels of the seven-segment
// serial driver. For every character taken in it predicts the serial beats
// from its own copy of the font and registers, and compares every beat sent
// out, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sscsd_scoreboard (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_index,
    input  logic  i_cfg_data,
    sscsd_in_if   in_mon,
    sscsd_out_if  out_mon,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic       serial_bit;
        logic [7:0] segment_pattern;
        logic       symbol_known;
        logic       last_bit;
    } t_serial_beat;

    localparam int GLYPH_COUNT = 43;
    localparam int SLOT_SPACE  = 43;
    localparam int SLOT_NONE   = -1;

    // Bit 7 is segment a, bit 0 the decimal point.
    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6,
        8'hEE, 8'h3E, 8'h1A, 8'h7A, 8'h9E, 8'h8E, 8'hBC, 8'h6E, 8'h2E, 8'h60,
        8'h20, 8'hF8, 8'h1C, 8'h2A, 8'hFC, 8'h3A, 8'hCE, 8'hE6, 8'h0A, 8'hB6,
        8'h1E, 8'h7C, 8'h38, 8'h76, 8'h10, 8'h02, 8'h12, 8'h9C, 8'hF0, 8'h44,
        8'h10, 8'h01, 8'h01
    };

    t_serial_beat expected_beats[$];
    logic         invert_on;
    logic         low_first_on;

    assign o_pending = expected_beats.size();

    initial o_fail_count = 0;

    function automatic int glyph_slot(input logic [7:0] code);
        if (code >= 8'h30 && code <= 8'h39) return int'(code - 8'h30);
        if (code >= 8'h41 && code <= 8'h48) return int'(code - 8'h41) + 10;
        if (code >= 8'h61 && code <= 8'h67) return int'(code - 8'h61) + 10;
        case (code)
            8'h68:        return 18;
            8'h49:        return 19;
            8'h69:        return 20;
            8'h4A, 8'h6A: return 21;
            8'h4C:        return 22;
            8'h4E, 8'h6E: return 23;
            8'h4F:        return 24;
            8'h6F:        return 25;
            8'h50:        return 26;
            8'h51, 8'h71: return 27;
            8'h52, 8'h72: return 28;
            8'h53, 8'h73: return 29;
            8'h54, 8'h74: return 30;
            8'h55:        return 31;
            8'h75:        return 32;
            8'h59, 8'h79: return 33;
            8'h5F:        return 34;
            8'h2D:        return 35;
            8'h3D:        return 36;
            8'h5B:        return 37;
            8'h5D:        return 38;
            8'h22:        return 39;
            8'h27:        return 40;
            8'h2E:        return 41;
            8'h2C:        return 42;
            8'h20:        return SLOT_SPACE;
            default:      return SLOT_NONE;
        endcase
    endfunction

    task automatic predict_beats(input logic [7:0] code);
        int           slot;
        int           pos;
        logic [7:0]   pattern;
        t_serial_beat beat;
        slot = glyph_slot(code);
        if (slot == SLOT_NONE) begin
            // A rejected character gives one closing beat and shifts nothing.
            beat.serial_bit      = 1'b0;
            beat.segment_pattern = 8'h00;
            beat.symbol_known    = 1'b0;
            beat.last_bit        = 1'b1;
            expected_beats.push_back(beat);
        end else begin
            pattern = (slot < GLYPH_COUNT) ? GLYPH_ROM[slot] : 8'h00;
            if (invert_on) pattern = ~pattern;
            for (int k = 0; k < 8; k++) begin
                pos                  = low_first_on ? k : 7 - k;
                beat.serial_bit      = pattern[pos];
                beat.segment_pattern = pattern;
                beat.symbol_known    = 1'b1;
                beat.last_bit        = (k == 7);
                expected_beats.push_back(beat);
            end
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic check_beat();
        t_serial_beat want;
        if (expected_beats.size() == 0) begin
            $error("serial beat with no character waiting: bit %0d pattern %0h",
                   out_mon.serial_bit, out_mon.segment_pattern);
            o_fail_count++;
        end else begin
            want = expected_beats.pop_front();
            compare_field("serial_bit", want.serial_bit, out_mon.serial_bit);
            compare_field("segment_pattern", want.segment_pattern, out_mon.segment_pattern);
            compare_field("symbol_known", want.symbol_known, out_mon.symbol_known);
            compare_field("last_bit", want.last_bit, out_mon.last_bit);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            invert_on    = 1'b0;
            low_first_on = 1'b0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sscsd_pkg::CFG_INVERT) invert_on = i_cfg_data;
                else low_first_on = i_cfg_data;
            end
            // Output first, so that a beat can never match a character taken
            // in on the same edge.
            if (out_mon.valid && out_mon.ready) check_beat();
            if (in_mon.valid && in_mon.ready) predict_beats(in_mon.char_code);
        end
    end

endmodule

// ===== verif/seven_segment_char_serial_driver_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_char_serial_driver_test
// Drives characters and register settings into the serial driver with random
// gaps on the input and random back-pressure on the output, and leaves the checking
// to sscsd_scoreboard, whose failure and pending counts decide the verdict.
// ----------------------------------------------------------------------------
module seven_segment_char_serial_driver_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 200;
    localparam int PHASE_ITEMS   = 25;

    localparam logic [7:0] DIRECTED [18] = '{
        8'h30, 8'h39, 8'h41, 8'h61, 8'h67, 8'h68, 8'h38, 8'h20, 8'h27,
        8'h22, 8'h2C, 8'h2E, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h4B, 8'h5A
    };

    localparam logic PHASE_INVERT [4]    = '{1'b1, 1'b0, 1'b1, 1'b0};
    localparam logic PHASE_LOW_FIRST [4] = '{1'b0, 1'b1, 1'b1, 1'b0};

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_index;
    logic cfg_data;
    int   fail_total;
    int   pending_beats;
    int   cycle_count;
    bit   idle_on;
    bit   hold_req;

    sscsd_in_if  char_ch ();
    sscsd_out_if bit_ch ();

    seven_segment_char_serial_driver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (char_ch),
        .o_out       (bit_ch)
    );

    sscsd_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .in_mon       (char_ch),
        .out_mon      (bit_ch),
        .o_fail_count (fail_total),
        .o_pending    (pending_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycle_count = 0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        int gap_left;
        hold_left = 0;
        gap_left  = 0;
        bit_ch.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                bit_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                bit_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(1, 11) - 1;
                bit_ch.ready <= 1'b0;
            end else begin
                bit_ch.ready <= 1'b1;
            end
        end
    end

    // Mostly printable codes, where the font lives, and some from the full range.
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h20, 8'h7F));
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a clock edge; returns at the edge where the beat is taken.
    task automatic send_char(input logic [7:0] code);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= code;
        do @(posedge i_clk); while (!char_ch.ready);
    endtask

    task automatic settle();
        char_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge i_clk);
    endtask

    initial begin
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= 8'h00;
        cfg_we            <= 1'b0;
        cfg_index         <= sscsd_pkg::CFG_INVERT;
        cfg_data          <= 1'b0;
        i_rst_n           <= 1'b0;
        idle_on  = 1'b1;
        hold_req = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The registers keep their reset values for the directed characters.
        foreach (DIRECTED[i]) send_char(DIRECTED[i]);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(sscsd_pkg::CFG_INVERT, PHASE_INVERT[ph]);
            write_reg(sscsd_pkg::CFG_LSB_FIRST, PHASE_LOW_FIRST[ph]);
            cfg_we <= 1'b0;
            // The receiver stops for a long while and the sender keeps on
            // offering, so the block fills up and pushes back.
            if (ph == 1) hold_req = 1'b1;
            if (ph == 3) idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph < 3 && n % 8 == 0) idle_on = ($urandom_range(0, 3) != 0);
                send_char(pick_char());
            end
            settle();
        end

        repeat (16) @(posedge i_clk);
        if (fail_total == 0 && pending_beats == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
